// ----- src/spq_pkg.sv -----
// shared types and constants for the sorted priority queue
package spq_pkg;

  localparam int CAPACITY   = 16;
  localparam int ID_BITS    = 16;
  localparam int PRIO_BITS  = 8;
  localparam int CNT_BITS   = $clog2(CAPACITY + 1);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef enum logic [1:0] {
    MODE_HOLD   = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_REMOVE = 2'd2
  } mode_t;

  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic [1:0]           op;
    logic [ID_BITS-1:0]   entry_id;
    logic [PRIO_BITS-1:0] entry_priority;
  } in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [ID_BITS-1:0]   removed_id;
    logic [PRIO_BITS-1:0] removed_priority;
    logic [CNT_BITS-1:0]  entry_count;
    logic                 head_valid;
    logic [ID_BITS-1:0]   head_id;
    logic [PRIO_BITS-1:0] head_priority;
  } out_t;

  // broadcast to every cell
  typedef struct packed {
    mode_t              mode;
    logic               by_id;
    entry_t             new_entry;
    logic [ID_BITS-1:0] key;
  } cell_ctrl_t;

  // what a cell hands to its neighbors
  typedef struct packed {
    entry_t entry;
    logic   valid;
    logic   ge;
    logic   hit;
  } cell_link_t;

endpackage

// ----- src/spq_cell.sv -----
// one slot of the sorted chain: holds an entry and shifts with its neighbors
module spq_cell (
  input  logic                clk,
  input  logic                rst,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  spq_pkg::cell_link_t left,
  input  spq_pkg::cell_link_t right,
  output spq_pkg::cell_link_t link,
  output logic                first
);

  spq_pkg::entry_t entry;
  spq_pkg::entry_t entry_next;
  logic            valid;
  logic            valid_next;
  logic            match;

  always_comb begin
    link.entry = entry;
    link.valid = valid;
    link.ge    = valid && (entry.prio >= ctrl.new_entry.prio);
    match      = valid && (!ctrl.by_id || (entry.id == ctrl.key));
    link.hit   = left.hit || match;
    first      = match && !left.hit;
  end

  always_comb begin
    entry_next = entry;
    valid_next = valid;
    case (ctrl.mode)
      spq_pkg::MODE_INSERT: begin
        if (!link.ge) begin
          // the first cell that is not ahead takes the new entry, the rest shift back
          entry_next = left.ge ? ctrl.new_entry : left.entry;
        end
        valid_next = valid || left.valid;
      end
      spq_pkg::MODE_REMOVE: begin
        if (link.hit) begin
          entry_next = right.entry;
          valid_next = right.valid;
        end
      end
      default: begin
        entry_next = entry;
        valid_next = valid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

// ----- src/sorted_priority_task_queue_top.sv -----
// top level: command decode, chain of slot cells and result register
// result and strobe are registered at the edge that accepts the command
// throughput: one item per cycle unless busy; all cells compare and shift together
// busy is high during reset and until the edge that samples rst low; no other stall
// reset: sync active-high rst empties the queue and clears the strobe
module sorted_priority_task_queue_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  spq_pkg::in_t  cmd,
  output logic          busy,
  output logic          strobe,
  output spq_pkg::out_t result
);

  localparam int N = spq_pkg::CAPACITY;

  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::cell_link_t links [N];
  spq_pkg::cell_link_t lefts [N];
  spq_pkg::cell_link_t rights[N];
  logic [N-1:0]        firsts;

  logic [spq_pkg::CNT_BITS-1:0] count;
  logic [spq_pkg::CNT_BITS-1:0] count_next;
  logic                         accept;
  logic                         is_empty;
  logic                         is_full;
  logic                         found;
  logic [1:0]                   status;
  spq_pkg::entry_t              removed;
  spq_pkg::out_t                res_next;

  assign accept   = start && !busy;
  assign is_empty = (count == '0);
  assign is_full  = (count == spq_pkg::CNT_BITS'(N));
  assign found    = links[N-1].hit;

  always_comb begin
    ctrl.by_id          = (cmd.op == spq_pkg::OP_REMOVE);
    ctrl.new_entry.id   = cmd.entry_id;
    ctrl.new_entry.prio = cmd.entry_priority;
    ctrl.key            = cmd.entry_id;
    ctrl.mode           = spq_pkg::MODE_HOLD;
    status              = spq_pkg::ST_OK;
    count_next          = count;
    case (cmd.op)
      spq_pkg::OP_INSERT: begin
        if (is_full) begin
          status = spq_pkg::ST_FULL;
        end else begin
          ctrl.mode  = spq_pkg::MODE_INSERT;
          count_next = count + 1'b1;
        end
      end
      spq_pkg::OP_POP: begin
        if (is_empty) begin
          status = spq_pkg::ST_EMPTY;
        end else begin
          ctrl.mode  = spq_pkg::MODE_REMOVE;
          count_next = count - 1'b1;
        end
      end
      spq_pkg::OP_REMOVE: begin
        if (is_empty) begin
          status = spq_pkg::ST_EMPTY;
        end else if (!found) begin
          status = spq_pkg::ST_NOT_FOUND;
        end else begin
          ctrl.mode  = spq_pkg::MODE_REMOVE;
          count_next = count - 1'b1;
        end
      end
      default: begin
        ctrl.mode = spq_pkg::MODE_HOLD;
      end
    endcase
    if (!accept) begin
      ctrl.mode  = spq_pkg::MODE_HOLD;
      count_next = count;
    end
  end

  // chain ends: in front of the head sits an always-ahead valid source
  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (i == 0) begin
        lefts[i].entry = ctrl.new_entry;
        lefts[i].valid = 1'b1;
        lefts[i].ge    = 1'b1;
        lefts[i].hit   = !ctrl.by_id;
      end else begin
        lefts[i] = links[i-1];
      end
      if (i == N - 1) begin
        rights[i].entry = ctrl.new_entry;
        rights[i].valid = 1'b0;
        rights[i].ge    = 1'b0;
        rights[i].hit   = 1'b0;
      end else begin
        rights[i] = links[i+1];
      end
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    spq_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .left  (lefts[g]),
      .right (rights[g]),
      .link  (links[g]),
      .first (firsts[g])
    );
  end

  // one-hot pick of the removed entry
  always_comb begin
    removed = '0;
    if (ctrl.by_id) begin
      for (int i = 0; i < N; i++) begin
        if (firsts[i]) begin
          removed = removed | links[i].entry;
        end
      end
    end else begin
      removed = links[0].entry;
    end
  end

  // head after the operation, taken from what the cells will hold
  always_comb begin
    res_next                  = '0;
    res_next.status           = status;
    res_next.entry_count      = count_next;
    if (status == spq_pkg::ST_OK && ctrl.mode == spq_pkg::MODE_REMOVE) begin
      res_next.removed_id       = removed.id;
      res_next.removed_priority = removed.prio;
    end
    res_next.head_valid = (count_next != '0);
    if (count_next != '0) begin
      case (ctrl.mode)
        spq_pkg::MODE_INSERT: begin
          if (links[0].ge) begin
            res_next.head_id       = links[0].entry.id;
            res_next.head_priority = links[0].entry.prio;
          end else begin
            res_next.head_id       = ctrl.new_entry.id;
            res_next.head_priority = ctrl.new_entry.prio;
          end
        end
        spq_pkg::MODE_REMOVE: begin
          if (links[0].hit) begin
            res_next.head_id       = links[1].entry.id;
            res_next.head_priority = links[1].entry.prio;
          end else begin
            res_next.head_id       = links[0].entry.id;
            res_next.head_priority = links[0].entry.prio;
          end
        end
        default: begin
          res_next.head_id       = links[0].entry.id;
          res_next.head_priority = links[0].entry.prio;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= res_next;
    end
    if (rst) begin
      count  <= '0;
      strobe <= 1'b0;
      busy   <= 1'b1;
    end else begin
      count  <= count_next;
      strobe <= accept;
      busy   <= 1'b0;
    end
  end

endmodule

// ----- src/spq_checker.sv -----
// port-level checker for the sorted priority queue, bound to the top level
module spq_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          strobe,
  input spq_pkg::out_t result
);

  a_strobe_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> strobe)
    else $error("no result after accepted item");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !strobe)
    else $error("result without accepted item");

  a_head_count: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (result.head_valid == (result.entry_count != '0)))
    else $error("head valid disagrees with count");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.status == spq_pkg::ST_FULL) |->
      (result.entry_count == spq_pkg::CNT_BITS'(spq_pkg::CAPACITY)))
    else $error("full status with room left");

  a_empty_nothing: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.status == spq_pkg::ST_EMPTY) |->
      (result.entry_count == '0 && result.removed_id == '0 &&
       result.removed_priority == '0))
    else $error("empty status with stored or removed entries");

endmodule

bind sorted_priority_task_queue_top spq_checker u_spq_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .result (result)
);
